// ===== rtl/mrfe_pkg.sv =====
// Shared constants, types and helper functions of the magic resync frame extractor.
package mrfe_pkg;

   // Frame geometry
   localparam int MAX_FRAME_BYTES = 128;
   localparam int MIN_FRAME_BYTES = 12;
   localparam int HEADER_BYTES    = 8;
   localparam int MAGIC_BYTES     = 4;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
   localparam int MATCH_W         = 3;
   localparam int BYTE_W          = 8;
   localparam int OFFSET_W        = 7;
   localparam int TYPE_W          = 32;
   localparam int COUNT_W         = 16;
   localparam int CSR_INDEX_W     = 2;

   // Register reset values
   localparam int BROADCAST_LEN_RESET = 36;
   localparam int SEND_LEN_RESET      = 104;
   localparam int DEFAULT_LEN_RESET   = 16;

   // Frame type codes
   localparam logic [TYPE_W-1:0] TYPE_BROADCAST   = 32'd0;
   localparam logic [TYPE_W-1:0] TYPE_HOST_SEND   = 32'd5;
   localparam logic [TYPE_W-1:0] TYPE_CLIENT_SEND = 32'd6;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BROADCAST_LEN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEND_LEN      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_LEN   = 2'd2;

   // Word held in the input register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } mrfe_item_type;

   // Clamped frame lengths from the register file
   typedef struct packed {
      logic [LEN_W-1:0] broadcast_len;
      logic [LEN_W-1:0] send_len;
      logic [LEN_W-1:0] default_len;
   } mrfe_len_type;

   // Expected magic byte at a given match position
   function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         2'd0:    b = 8'h52; // R
         2'd1:    b = 8'h46; // F
         2'd2:    b = 8'h55; // U
         default: b = 8'h31; // 1
      endcase
      return b;
   endfunction

   // Limit a written length to the supported frame size range
   function automatic logic [LEN_W-1:0] clamp_len(input logic [BYTE_W-1:0] v);
      logic [LEN_W-1:0] r;
      if ({1'b0, v} < 9'(MIN_FRAME_BYTES)) begin
         r = LEN_W'(MIN_FRAME_BYTES);
      end else if ({1'b0, v} > 9'(MAX_FRAME_BYTES)) begin
         r = LEN_W'(MAX_FRAME_BYTES);
      end else begin
         r = LEN_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== rtl/magic_resync_frame_extractor_core.sv =====
// Top level of the magic resync frame extractor.
//
// Usage:
//   req_*  carries one stream byte per word (req_valid / req_stall).
//   rsp_*  carries one frame body byte per word with its offset, the frame
//          type, a last-byte flag and the running frame count.
//   csr_*  writes the three frame length registers (index 0 broadcast,
//          1 host/client send, 2 all other types); csr_ready is always high.
//          Write only while no bytes are in flight.
// Path: a body byte passes through the input register and then the result
//   register before rsp_valid rises. Magic and type bytes produce no word.
// Throughput: one byte per cycle while no held result stalls a body byte, set
//   by the single input register feeding the parser and its result register.
// Reset: synchronous; clears the hunt, frame count and both registers'
//   valid flags, and loads the default lengths (36, 104, 16).
// Stall: while rsp_stall holds a result, magic and type bytes still pass; a body
//   byte waits in the input register and req_stall rises until the result moves.
module magic_resync_frame_extractor_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mrfe_pkg::BYTE_W-1:0]       req_in_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mrfe_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [mrfe_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   output logic [mrfe_pkg::TYPE_W-1:0]       rsp_frame_type,
   output logic                              rsp_is_last,
   output logic [mrfe_pkg::COUNT_W-1:0]      rsp_frame_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mrfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mrfe_pkg::BYTE_W-1:0]       csr_data
);
   import mrfe_pkg::*;

   mrfe_item_type item;
   mrfe_len_type  lengths;
   logic          taken;

   mrfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .lengths   (lengths)
   );

   mrfe_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .taken       (taken),
      .item        (item)
   );

   mrfe_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .item            (item),
      .taken           (taken),
      .lengths         (lengths),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_is_last     (rsp_is_last),
      .rsp_frame_count (rsp_frame_count)
   );

endmodule

// ===== rtl/mrfe_csr.sv =====
// Frame length register file, stored already clamped to the legal range.
module mrfe_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mrfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mrfe_pkg::BYTE_W-1:0]    csr_data,
   output mrfe_pkg::mrfe_len_type         lengths
);
   import mrfe_pkg::*;

   mrfe_len_type len_ff;
   mrfe_len_type len_in;

   assign csr_ready = 1'b1;
   assign lengths   = len_ff;

   // Decode the write; unknown indexes drop the word
   always_comb begin
      len_in = len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BROADCAST_LEN: len_in.broadcast_len = clamp_len(csr_data);
            CSR_SEND_LEN:      len_in.send_len      = clamp_len(csr_data);
            CSR_DEFAULT_LEN:   len_in.default_len   = clamp_len(csr_data);
            default:           len_in = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff.broadcast_len <= clamp_len(BYTE_W'(BROADCAST_LEN_RESET));
         len_ff.send_len      <= clamp_len(BYTE_W'(SEND_LEN_RESET));
         len_ff.default_len   <= clamp_len(BYTE_W'(DEFAULT_LEN_RESET));
      end else begin
         len_ff <= len_in;
      end
   end

endmodule

// ===== rtl/mrfe_in_reg.sv =====
// Input register: captures one stream word and holds it until the parser takes it.
module mrfe_in_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mrfe_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                        taken,
   output mrfe_pkg::mrfe_item_type     item
);
   import mrfe_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              accept;

   // Hold off the sender only while a word sits here and is not taken
   assign req_stall = valid_ff && !taken;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_in_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

// ===== rtl/mrfe_parser.sv =====
// Magic hunt, header assembly and body emission with the result register.
module mrfe_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  mrfe_pkg::mrfe_item_type       item,
   output logic                          taken,
   input  mrfe_pkg::mrfe_len_type        lengths,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mrfe_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [mrfe_pkg::OFFSET_W-1:0] rsp_byte_offset,
   output logic [mrfe_pkg::TYPE_W-1:0]   rsp_frame_type,
   output logic                          rsp_is_last,
   output logic [mrfe_pkg::COUNT_W-1:0]  rsp_frame_count
);
   import mrfe_pkg::*;

   // Frame state
   logic [MATCH_W-1:0] match_ff, match_in;
   logic [TYPE_W-1:0]  type_ff, type_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Result register
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic [TYPE_W-1:0]   out_type_ff;
   logic                out_last_ff;
   logic [COUNT_W-1:0]  out_count_ff;

   logic               hunting;
   logic               in_body;
   logic               out_free;
   logic               emit;
   logic               last;
   logic [LEN_W-1:0]   pos_plus_one;
   logic [TYPE_W-1:0]  type_shift;
   logic [LEN_W-1:0]   picked_len;

   assign hunting      = (match_ff != MATCH_W'(MAGIC_BYTES));
   assign in_body      = !hunting && (pos_ff >= POS_W'(HEADER_BYTES));
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign taken        = item.valid && (!in_body || out_free);
   assign emit         = taken && in_body;
   assign pos_plus_one = LEN_W'(pos_ff) + LEN_W'(1);
   assign last         = (pos_plus_one >= len_ff);
   assign type_shift   = {type_ff[TYPE_W-BYTE_W-1:0], item.data};

   // Select the frame length from the completed type word
   always_comb begin
      if (type_shift == TYPE_BROADCAST) begin
         picked_len = lengths.broadcast_len;
      end else if (type_shift == TYPE_HOST_SEND || type_shift == TYPE_CLIENT_SEND) begin
         picked_len = lengths.send_len;
      end else begin
         picked_len = lengths.default_len;
      end
   end

   // Advance the frame state on each taken word
   always_comb begin
      match_in = match_ff;
      type_in  = type_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      count_in = count_ff;
      if (taken) begin
         if (hunting) begin
            if (item.data == magic_byte(match_ff[1:0])) begin
               match_in = match_ff + MATCH_W'(1);
               if (match_ff == MATCH_W'(MAGIC_BYTES - 1)) begin
                  pos_in  = POS_W'(MAGIC_BYTES);
                  type_in = '0;
               end
            end else if (item.data == magic_byte(2'd0)) begin
               match_in = MATCH_W'(1);
            end else begin
               match_in = '0;
            end
         end else if (!in_body) begin
            type_in = type_shift;
            pos_in  = pos_ff + POS_W'(1);
            if (pos_ff == POS_W'(HEADER_BYTES - 1)) begin
               len_in = picked_len;
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (last) begin
               count_in = count_ff + COUNT_W'(1);
               match_in = '0;
               pos_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
         type_ff  <= '0;
         pos_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else begin
         match_ff <= match_in;
         type_ff  <= type_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   // Load the result register when a body byte goes out, drop it once taken
   always_comb begin
      if (out_free) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff   <= item.data;
         out_offset_ff <= OFFSET_W'(pos_ff);
         out_type_ff   <= type_ff;
         out_last_ff   <= last;
         out_count_ff  <= count_ff + COUNT_W'(1);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_byte_offset = out_offset_ff;
   assign rsp_frame_type  = out_type_ff;
   assign rsp_is_last     = out_last_ff;
   assign rsp_frame_count = out_count_ff;

endmodule

// ===== rtl/mrfe_checker.sv =====
// Port-level checks of the frame extractor, bound to the top level.
module mrfe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [mrfe_pkg::BYTE_W-1:0]       rsp_out_byte,
   input logic [mrfe_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   input logic [mrfe_pkg::TYPE_W-1:0]       rsp_frame_type,
   input logic                              rsp_is_last,
   input logic [mrfe_pkg::COUNT_W-1:0]      rsp_frame_count
);
   import mrfe_pkg::*;

   // A stalled result holds its whole word
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
            && $stable(rsp_byte_offset) && $stable(rsp_is_last)
            && $stable(rsp_frame_type) && $stable(rsp_frame_count);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled result changed");

   // The cycle after reset shows no result
   property p_reset_empty;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result valid after reset");

   // A byte right after a non-last byte stays in the same frame at the next offset
   property p_same_frame;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_stall && !rsp_is_last ##1 rsp_valid |->
            rsp_frame_count == $past(rsp_frame_count)
            && rsp_frame_type == $past(rsp_frame_type)
            && rsp_byte_offset == $past(rsp_byte_offset) + OFFSET_W'(1);
   endproperty
   a_same_frame: assert property (p_same_frame) else $error("frame continuity broken");

   // A byte right after the last byte opens the next frame count
   property p_next_frame;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_stall && rsp_is_last ##1 rsp_valid |->
            rsp_frame_count == $past(rsp_frame_count) + COUNT_W'(1);
   endproperty
   a_next_frame: assert property (p_next_frame) else $error("frame count skipped");

endmodule

bind magic_resync_frame_extractor_core mrfe_checker u_mrfe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_offset (rsp_byte_offset),
   .rsp_frame_type  (rsp_frame_type),
   .rsp_is_last     (rsp_is_last),
   .rsp_frame_count (rsp_frame_count)
);
